>>> design/asr_pkg.sv
// ----------------------------------------------------------------------------
// asr_pkg
// Shared types and codes for the adaptive slicer serial receiver.
// ----------------------------------------------------------------------------
package asr_pkg;

   localparam int SAMPLE_W   = 8;
   localparam int BYTE_BITS  = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CLOCK_LOST_RANGE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DATA_IDLE_RANGE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERT_CLOCK     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERT_DATA      = 2'd3;

   // configuration reset values
   localparam logic [SAMPLE_W-1:0] CLOCK_LOST_RANGE_RST = 8'd20;
   localparam logic [SAMPLE_W-1:0] DATA_IDLE_RANGE_RST  = 8'd20;

   // receiver phase codes
   localparam logic [2:0] PH_IDLE_HIGH = 3'd0;
   localparam logic [2:0] PH_IDLE_LOW  = 3'd1;
   localparam logic [2:0] PH_READ_HIGH = 3'd2;
   localparam logic [2:0] PH_READ_LOW  = 3'd3;
   localparam logic [2:0] PH_FINISHED  = 3'd4;
   localparam logic [2:0] PH_LOST      = 3'd5;

   // sequencer codes
   localparam logic [1:0] SEQ_IDLE = 2'd0;
   localparam logic [1:0] SEQ_SCAN = 2'd1;
   localparam logic [1:0] SEQ_EVAL = 2'd2;

   // window control from the sequencer
   typedef struct packed {
      logic push;    // load newest sample, restart span
      logic rotate;  // advance the window by one place
      logic take;    // fold the entry at place 0 into the span
   } win_ctrl_type;

   // configuration as seen by the phase machine
   typedef struct packed {
      logic [SAMPLE_W-1:0] clock_lost_range;
      logic [SAMPLE_W-1:0] data_idle_range;
      logic                invert_clock;
      logic                invert_data;
   } cfg_type;

   // window span and newest sample
   typedef struct packed {
      logic [SAMPLE_W-1:0] min;
      logic [SAMPLE_W-1:0] max;
      logic [SAMPLE_W-1:0] newest;
   } span_type;

   // one result item
   typedef struct packed {
      logic                byte_valid;
      logic [BYTE_BITS-1:0] received_byte;
      logic                clock_lost;
   } result_type;

endpackage

>>> design/asr_req_if.sv
// ----------------------------------------------------------------------------
// asr_req_if
// Sample channel: one clock line and one data line sample per item.
// ----------------------------------------------------------------------------
interface asr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] clock_sample;
   logic [7:0] data_sample;

   modport source (output valid, output clock_sample, output data_sample, input ready);
   modport sink   (input valid, input clock_sample, input data_sample, output ready);
endinterface

>>> design/asr_rsp_if.sv
// ----------------------------------------------------------------------------
// asr_rsp_if
// Result channel: byte strobe, received byte and clock lost flag.
// ----------------------------------------------------------------------------
interface asr_rsp_if;
   logic       valid;
   logic       ready;
   logic       byte_valid;
   logic [7:0] received_byte;
   logic       clock_lost;

   modport source (output valid, output byte_valid, output received_byte,
                   output clock_lost, input ready);
   modport sink   (input valid, input byte_valid, input received_byte,
                   input clock_lost, output ready);
endinterface

>>> design/asr_window.sv
// ----------------------------------------------------------------------------
// asr_window
// Sliding sample window with a shared min/max compare unit. While rotate is
// high the window rotates one place a cycle; entries pass the unit in turn.
// ----------------------------------------------------------------------------
module asr_window #(
   parameter int DEPTH = 16
) (
   input  logic                  clock,
   input  asr_pkg::win_ctrl_type ctrl,
   input  logic [7:0]            sample,
   output asr_pkg::span_type     span
);
   import asr_pkg::*;

   logic [SAMPLE_W-1:0] window_ff [DEPTH];
   logic [SAMPLE_W-1:0] window_in [DEPTH];
   logic [SAMPLE_W-1:0] min_ff, min_in;
   logic [SAMPLE_W-1:0] max_ff, max_in;
   logic [SAMPLE_W-1:0] newest_ff, newest_in;

   // shift in on push, rotate towards place 0 while scanning
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         window_in[i] = window_ff[i];
      end
      if (ctrl.push) begin
         window_in[0] = sample;
         for (int i = 1; i < DEPTH; i++) begin
            window_in[i] = window_ff[i-1];
         end
      end else if (ctrl.rotate) begin
         for (int i = 0; i < DEPTH - 1; i++) begin
            window_in[i] = window_ff[i+1];
         end
         window_in[DEPTH-1] = window_ff[0];
      end
   end

   // shared compare unit: fold place 0 into the running span
   always_comb begin
      min_in    = min_ff;
      max_in    = max_ff;
      newest_in = newest_ff;
      if (ctrl.push) begin
         min_in    = sample;
         max_in    = sample;
         newest_in = sample;
      end else if (ctrl.take) begin
         if (window_ff[0] < min_ff) begin
            min_in = window_ff[0];
         end
         if (window_ff[0] > max_ff) begin
            max_in = window_ff[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         window_ff[i] <= window_in[i];
      end
      min_ff    <= min_in;
      max_ff    <= max_in;
      newest_ff <= newest_in;
   end

   assign span.min    = min_ff;
   assign span.max    = max_ff;
   assign span.newest = newest_ff;

endmodule

>>> design/asr_phase_fsm.sv
// ----------------------------------------------------------------------------
// asr_phase_fsm
// Slices both lines against their window midpoints and runs the receiver
// phase machine: start bit, eight data bits MSB first, then the byte.
// ----------------------------------------------------------------------------
module asr_phase_fsm (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  asr_pkg::cfg_type    cfg,
   input  asr_pkg::span_type   clk_span,
   input  asr_pkg::span_type   dat_span,
   output asr_pkg::result_type result
);
   import asr_pkg::*;

   logic [2:0]           phase_ff, phase_in;
   logic [3:0]           bits_ff, bits_in;
   logic [BYTE_BITS-1:0] shift_ff, shift_in;

   logic [SAMPLE_W-1:0] clk_range, dat_range;
   logic [SAMPLE_W:0]   clk_sum, dat_sum;
   logic [SAMPLE_W-1:0] clk_thr, dat_thr;
   logic                lost, clk_high, data_high;
   logic                valid;
   logic [BYTE_BITS-1:0] byte_out;

   // slice both lines
   always_comb begin
      clk_range = clk_span.max - clk_span.min;
      dat_range = dat_span.max - dat_span.min;
      clk_sum   = {1'b0, clk_span.min} + {1'b0, clk_span.max};
      dat_sum   = {1'b0, dat_span.min} + {1'b0, dat_span.max};
      clk_thr   = clk_sum[SAMPLE_W:1];
      dat_thr   = dat_sum[SAMPLE_W:1];
      lost      = (clk_range <= cfg.clock_lost_range);
      clk_high  = !lost && ((clk_span.newest < clk_thr) == cfg.invert_clock);
      data_high = (dat_range <= cfg.data_idle_range) ||
                  ((dat_span.newest < dat_thr) == cfg.invert_data);
   end

   // phase transitions; a lost clock overrides all but the lost phase
   always_comb begin
      phase_in = phase_ff;
      bits_in  = bits_ff;
      shift_in = shift_ff;
      valid    = 1'b0;
      byte_out = '0;
      unique case (phase_ff)
         PH_IDLE_LOW: begin
            if (clk_high) begin
               phase_in = PH_IDLE_HIGH;
            end
         end
         PH_READ_HIGH: begin
            if (!clk_high) begin
               if (bits_ff < 4'(BYTE_BITS)) begin
                  shift_in = {shift_ff[BYTE_BITS-2:0], data_high};
                  bits_in  = bits_ff + 4'd1;
                  phase_in = PH_READ_LOW;
               end else begin
                  phase_in = PH_FINISHED;
               end
            end
         end
         PH_READ_LOW: begin
            if (clk_high) begin
               phase_in = PH_READ_HIGH;
            end
         end
         PH_FINISHED: begin
            valid    = 1'b1;
            byte_out = shift_ff;
            phase_in = clk_high ? PH_IDLE_HIGH : PH_IDLE_LOW;
         end
         PH_LOST: begin
            if (!lost) begin
               phase_in = clk_high ? PH_IDLE_HIGH : PH_IDLE_LOW;
            end
         end
         default: begin
            // idle high, and the unreachable codes behave the same
            phase_in = PH_IDLE_HIGH;
            if (!clk_high) begin
               if (data_high) begin
                  phase_in = PH_IDLE_LOW;
               end else begin
                  bits_in  = '0;
                  shift_in = '0;
                  phase_in = PH_READ_LOW;
               end
            end
         end
      endcase
      if (lost && phase_ff != PH_LOST) begin
         phase_in = PH_LOST;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE_HIGH;
         bits_ff  <= '0;
         shift_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         bits_ff  <= bits_in;
         shift_ff <= shift_in;
      end
   end

   assign result.byte_valid    = valid;
   assign result.received_byte = byte_out;
   assign result.clock_lost    = (phase_in == PH_LOST);

endmodule

>>> design/adaptive_slicer_serial_receiver_unit.sv
// Each sample item goes from acceptance to result through a load step that
// fills both windows, a scan that rotates the windows past the shared
// min/max compare units, and an evaluation step that slices the lines,
// steps the phase machine and loads the result register. One result item
// is produced per sample item. The block takes a new sample only when idle,
// which it may be while a result still waits in the output register; the
// evaluation cycle holds until that register is free. Configuration writes
// are taken on any cycle with csr_we high.
// ----------------------------------------------------------------------------
// adaptive_slicer_serial_receiver_unit
// Top level: sequencer, configuration registers, windows and result register.
// ----------------------------------------------------------------------------
module adaptive_slicer_serial_receiver_unit #(
   parameter int WINDOW_DEPTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   asr_req_if.sink                        req_chan,
   asr_rsp_if.source                      rsp_chan,
   input  logic                           csr_we,
   input  logic [asr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [asr_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import asr_pkg::*;

   localparam int CNT_W  = $clog2(WINDOW_DEPTH);
   localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);

   logic [1:0]        seq_ff, seq_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   cfg_type           cfg_ff, cfg_in;
   result_type        rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   win_ctrl_type ctrl;
   logic         step;
   logic         req_take;
   span_type     clk_span, dat_span;
   result_type   result;

   // configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_CLOCK_LOST_RANGE: cfg_in.clock_lost_range = csr_wdata;
            CSR_DATA_IDLE_RANGE:  cfg_in.data_idle_range  = csr_wdata;
            CSR_INVERT_CLOCK:     cfg_in.invert_clock     = csr_wdata[0];
            CSR_INVERT_DATA:      cfg_in.invert_data      = csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign req_chan.ready = (seq_ff == SEQ_IDLE);
   assign req_take       = req_chan.valid && req_chan.ready;

   // sequencer: load, scan the windows, evaluate
   always_comb begin
      seq_in       = seq_ff;
      cnt_in       = cnt_ff;
      fill_in      = fill_ff;
      ctrl         = '0;
      step         = 1'b0;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      unique case (seq_ff)
         SEQ_IDLE: begin
            if (req_take) begin
               ctrl.push = 1'b1;
               cnt_in    = '0;
               if (fill_ff != FILL_W'(WINDOW_DEPTH)) begin
                  fill_in = fill_ff + FILL_W'(1);
               end
               seq_in = SEQ_SCAN;
            end
         end
         SEQ_SCAN: begin
            ctrl.rotate = 1'b1;
            ctrl.take   = (FILL_W'(cnt_ff) < fill_ff);
            cnt_in      = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(WINDOW_DEPTH - 1)) begin
               seq_in = SEQ_EVAL;
            end
         end
         SEQ_EVAL: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               step         = 1'b1;
               rsp_in       = result;
               rsp_valid_in = 1'b1;
               seq_in       = SEQ_IDLE;
            end
         end
         default: begin
            seq_in = SEQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff                  <= SEQ_IDLE;
         cnt_ff                  <= '0;
         fill_ff                 <= '0;
         cfg_ff.clock_lost_range <= CLOCK_LOST_RANGE_RST;
         cfg_ff.data_idle_range  <= DATA_IDLE_RANGE_RST;
         cfg_ff.invert_clock     <= 1'b0;
         cfg_ff.invert_data      <= 1'b0;
         rsp_valid_ff            <= 1'b0;
      end else begin
         seq_ff       <= seq_in;
         cnt_ff       <= cnt_in;
         fill_ff      <= fill_in;
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   asr_window #(.DEPTH(WINDOW_DEPTH)) u_clk_window (
      .clock  (clock),
      .ctrl   (ctrl),
      .sample (req_chan.clock_sample),
      .span   (clk_span)
   );

   asr_window #(.DEPTH(WINDOW_DEPTH)) u_dat_window (
      .clock  (clock),
      .ctrl   (ctrl),
      .sample (req_chan.data_sample),
      .span   (dat_span)
   );

   asr_phase_fsm u_phase_fsm (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .cfg      (cfg_ff),
      .clk_span (clk_span),
      .dat_span (dat_span),
      .result   (result)
   );

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.byte_valid    = rsp_ff.byte_valid;
   assign rsp_chan.received_byte = rsp_ff.received_byte;
   assign rsp_chan.clock_lost    = rsp_ff.clock_lost;

endmodule

>>> design/asr_checker.sv
// ----------------------------------------------------------------------------
// asr_checker
// Port-level checks on the receiver, bound to the top level.
// ----------------------------------------------------------------------------
module asr_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       byte_valid,
   input logic [7:0] received_byte
);

   // a new item keeps the block busy for the next cycle
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("sample taken while the previous one is still in work");

   // a result appears only out of the busy period
   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result raised without an item in work");

   // no byte means a zero byte field
   a_zero_without_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !byte_valid) |-> (received_byte == 8'd0))
      else $error("received byte non-zero without byte strobe");

   // a stalled result holds its byte
   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(received_byte)))
      else $error("stalled result changed or dropped");

   // nothing is offered straight out of reset
   a_quiet_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid just after reset");

endmodule

bind adaptive_slicer_serial_receiver_unit asr_checker u_asr_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .byte_valid    (rsp_chan.byte_valid),
   .received_byte (rsp_chan.received_byte)
);

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the adaptive slicer serial receiver. A predictor
// slides its own sample windows, slices both lines and steps the receiver
// phases. Each result item is checked against the oldest prediction. The
// stimulus runs a lost-clock frame, sample extremes, then random frames,
// broken frames, noise and clock stalls under a sweep of settings.
// ----------------------------------------------------------------------------
module testbench;
   import asr_pkg::*;

   localparam int WIN_DEPTH     = 16;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int RANDOM_ITEMS  = 1200;
   localparam int SETTLE_CYCLES = 2 * (WIN_DEPTH + 2);
   localparam int PEND_DEPTH    = 8;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   asr_req_if req_chan ();
   asr_rsp_if rsp_chan ();

   adaptive_slicer_serial_receiver_unit #(
      .WINDOW_DEPTH(WIN_DEPTH)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // predictor state
   logic [7:0]  clk_win [WIN_DEPTH];
   logic [7:0]  dat_win [WIN_DEPTH];
   int unsigned win_fill;
   logic [2:0]  rx_phase;
   logic [3:0]  bit_count;
   logic [7:0]  shift_reg;
   cfg_type     cfg;

   // predictions in order of acceptance; written at pend_wr, read at pend_rd
   result_type pending_results [PEND_DEPTH];
   int pend_wr = 0;
   int pend_rd = 0;
   int error_count;
   int sent_count;
   int send_idle_pct;
   int recv_idle_pct;
   int timeout_cycles;

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // abort a hung run
   initial begin
      timeout_cycles = 0;
      while (timeout_cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         timeout_cycles++;
      end
      $display("testbench: done, errors");
      $finish;
   end

   // stall the result channel at random
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(negedge clock);
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic note_failure(input string msg);
      error_count++;
      if (error_count <= 10) $display("mismatch: %s", msg);
   endtask

   // min and max over the samples held
   function automatic void window_span(input logic [7:0] win [WIN_DEPTH],
                                       output logic [7:0] lo, output logic [7:0] hi);
      int i;
      lo = win[0];
      hi = win[0];
      for (i = 1; i < win_fill && i < WIN_DEPTH; i++) begin
         if (win[i] < lo) lo = win[i];
         if (win[i] > hi) hi = win[i];
      end
   endfunction

   // newest sample against the window midpoint, rounded down
   function automatic logic sliced_high(input logic [7:0] newest, lo, hi, input logic inv);
      logic [8:0] thr;
      thr = ({1'b0, lo} + {1'b0, hi}) >> 1;
      return ({1'b0, newest} < thr) == inv;
   endfunction

   // advance the receiver by one sample pair and return the result item
   function automatic result_type receive_step(input logic [7:0] cs, input logic [7:0] ds);
      result_type r;
      logic [7:0] clo, chi, dlo, dhi;
      logic lost, clk_hi, dat_hi;
      logic [2:0] nxt;
      int i;
      for (i = WIN_DEPTH - 1; i > 0; i--) begin
         clk_win[i] = clk_win[i-1];
         dat_win[i] = dat_win[i-1];
      end
      clk_win[0] = cs;
      dat_win[0] = ds;
      if (win_fill < WIN_DEPTH) win_fill++;
      window_span(clk_win, clo, chi);
      window_span(dat_win, dlo, dhi);

      lost   = (chi - clo) <= cfg.clock_lost_range;
      clk_hi = lost ? 1'b0 : sliced_high(clk_win[0], clo, chi, cfg.invert_clock);
      dat_hi = ((dhi - dlo) <= cfg.data_idle_range) ? 1'b1
               : sliced_high(dat_win[0], dlo, dhi, cfg.invert_data);

      r   = '0;
      nxt = rx_phase;
      case (rx_phase)
         PH_IDLE_LOW: begin
            if (clk_hi) nxt = PH_IDLE_HIGH;
         end
         PH_READ_HIGH: begin
            if (!clk_hi) begin
               if (bit_count < BYTE_BITS) begin
                  shift_reg = {shift_reg[6:0], dat_hi};
                  bit_count = bit_count + 4'd1;
                  nxt = PH_READ_LOW;
               end else begin
                  nxt = PH_FINISHED;
               end
            end
         end
         PH_READ_LOW: begin
            if (clk_hi) nxt = PH_READ_HIGH;
         end
         PH_FINISHED: begin
            r.byte_valid    = 1'b1;
            r.received_byte = shift_reg;
            nxt = clk_hi ? PH_IDLE_HIGH : PH_IDLE_LOW;
         end
         PH_LOST: begin
            if (!lost) nxt = clk_hi ? PH_IDLE_HIGH : PH_IDLE_LOW;
         end
         default: begin
            // idle high; unused codes behave the same
            nxt = PH_IDLE_HIGH;
            if (!clk_hi) begin
               if (dat_hi) begin
                  nxt = PH_IDLE_LOW;
               end else begin
                  bit_count = '0;
                  shift_reg = '0;
                  nxt = PH_READ_LOW;
               end
            end
         end
      endcase
      // a lost clock overrides every other move
      if (lost && rx_phase != PH_LOST) nxt = PH_LOST;
      rx_phase = nxt;
      r.clock_lost = (rx_phase == PH_LOST);
      return r;
   endfunction

   // check each result item against the oldest prediction
   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pend_wr == pend_rd) begin
            note_failure($sformatf("unpredicted result: byte_valid %0b byte %02h lost %0b",
                                   rsp_chan.byte_valid, rsp_chan.received_byte,
                                   rsp_chan.clock_lost));
         end else begin
            want = pending_results[pend_rd % PEND_DEPTH];
            pend_rd++;
            if (rsp_chan.byte_valid !== want.byte_valid)
               note_failure($sformatf("byte_valid expected %0b got %0b",
                                      want.byte_valid, rsp_chan.byte_valid));
            if (rsp_chan.received_byte !== want.received_byte)
               note_failure($sformatf("received_byte expected %02h got %02h",
                                      want.received_byte, rsp_chan.received_byte));
            if (rsp_chan.clock_lost !== want.clock_lost)
               note_failure($sformatf("clock_lost expected %0b got %0b",
                                      want.clock_lost, rsp_chan.clock_lost));
         end
      end
   end

   // offer one sample pair, hold until taken, record the prediction
   task automatic send_sample(input logic [7:0] cs, input logic [7:0] ds);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.clock_sample <= cs;
      req_chan.data_sample  <= ds;
      do @(posedge clock); while (!req_chan.ready);
      if (pend_wr - pend_rd >= PEND_DEPTH)
         note_failure("more items in flight than the prediction store holds");
      pending_results[pend_wr % PEND_DEPTH] = receive_step(cs, ds);
      pend_wr++;
      sent_count++;
      @(negedge clock);
   endtask

   task automatic program_reg(input logic [CSR_IDX_W-1:0] idx, input logic [7:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
   endtask

   // drain, then write all four registers
   task automatic apply_settings(input logic [7:0] lost_rng, input logic [7:0] idle_rng,
                                 input logic inv_clk, input logic inv_dat);
      req_chan.valid <= 1'b0;
      while (pend_wr != pend_rd) @(negedge clock);
      program_reg(CSR_CLOCK_LOST_RANGE, lost_rng);
      program_reg(CSR_DATA_IDLE_RANGE, idle_rng);
      program_reg(CSR_INVERT_CLOCK, {7'd0, inv_clk});
      program_reg(CSR_INVERT_DATA, {7'd0, inv_dat});
      csr_we <= 1'b0;
      cfg = '{lost_rng, idle_rng, inv_clk, inv_dat};
   endtask

   // data level on clock cycle cyc of a frame: start bit, byte MSB first, then high
   function automatic logic frame_bit(input logic [7:0] value, input int cyc);
      if (cyc == 0) return 1'b0;
      if (cyc <= BYTE_BITS) return value[BYTE_BITS - cyc];
      return 1'b1;
   endfunction

   // noisy analog sample for a logic level
   function automatic logic [7:0] level_sample(input logic lvl, input logic inv);
      if (lvl ^ inv) return 8'($urandom_range(255, 180));
      return 8'($urandom_range(75, 0));
   endfunction

   // one clock cycle: half items high, half items low, data held
   task automatic send_clock_cycle(input int half, input logic dbit);
      int k;
      for (k = 0; k < 2 * half; k++)
         send_sample(level_sample(k < half, cfg.invert_clock),
                     level_sample(dbit, cfg.invert_data));
   endtask

   // clock swing shrinks so the clock is lost on the very step the byte comes out
   task automatic test_lost_clock_at_finish();
      logic [7:0] value;
      logic [7:0] cs, ds;
      int idx;
      value = 8'hA5;
      apply_settings(8'd150, 8'd20, 1'b0, 1'b0);
      for (idx = 0; idx <= 22; idx++) begin
         if (idx % 2 == 1) cs = 8'd90;
         else cs = (idx <= 6) ? 8'd255 : 8'd200;
         if (idx < 2) ds = 8'd220;
         else ds = frame_bit(value, (idx - 2) / 2) ? 8'd220 : 8'd30;
         send_sample(cs, ds);
      end
   endtask

   // corner sample values on both lines
   task automatic test_sample_extremes();
      send_sample(8'd255, 8'd0);
      send_sample(8'd0, 8'd255);
      send_sample(8'd0, 8'd0);
      send_sample(8'd255, 8'd255);
      send_sample(8'd255, 8'd255);
      send_sample(8'd0, 8'd0);
   endtask

   // random traffic across a sweep of settings
   task automatic test_settings_sweep();
      int start_count, phase_end, phase, seg, half, cyc, cut, n, k;
      logic [7:0] value, hold;
      start_count = sent_count;
      phase = 0;
      while (sent_count - start_count < RANDOM_ITEMS) begin
         case (phase)
            0: apply_settings(8'd0, 8'd0, 1'b0, 1'b0);
            1: apply_settings(8'd255, 8'd255, 1'b1, 1'b1);
            2: apply_settings(8'd0, 8'd255, 1'b1, 1'b0);
            3: apply_settings(8'd255, 8'd0, 1'b0, 1'b1);
            default: begin
               if ($urandom_range(9) == 0)
                  apply_settings(8'($urandom_range(255)), 8'($urandom_range(255)),
                                 1'($urandom_range(1)), 1'($urandom_range(1)));
               else
                  apply_settings(8'($urandom_range(100)), 8'($urandom_range(100)),
                                 1'($urandom_range(1)), 1'($urandom_range(1)));
            end
         endcase
         phase_end = sent_count + ((phase < 4) ? 60 : 110);
         while (sent_count < phase_end) begin
            // receiver idles first, then sender, then neither
            if (sent_count - start_count < RANDOM_ITEMS / 3) begin
               send_idle_pct = 23;
               recv_idle_pct = 71;
            end else if (sent_count - start_count < 2 * RANDOM_ITEMS / 3) begin
               send_idle_pct = 71;
               recv_idle_pct = 23;
            end else begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
            seg   = $urandom_range(99);
            half  = ($urandom_range(9) == 0) ? 3 : $urandom_range(2, 1);
            value = 8'($urandom_range(255));
            if (seg < 80) begin
               // idle cycles with data high, then a frame, cut short now and then
               n = $urandom_range(3, 1);
               for (k = 0; k < n; k++) send_clock_cycle(half, 1'b1);
               cut = (seg < 70) ? 11 : $urandom_range(10, 1);
               for (cyc = 0; cyc < cut; cyc++) send_clock_cycle(half, frame_bit(value, cyc));
            end else if (seg < 90) begin
               // raw noise
               n = $urandom_range(8, 1);
               for (k = 0; k < n; k++)
                  send_sample(8'($urandom_range(255)), 8'($urandom_range(255)));
            end else begin
               // stall the clock line until it is lost
               hold = 8'($urandom_range(255));
               n = $urandom_range(20, 16);
               for (k = 0; k < n; k++) send_sample(hold, 8'($urandom_range(255)));
            end
         end
         phase++;
      end
   endtask

   initial begin
      req_chan.valid        <= 1'b0;
      req_chan.clock_sample <= '0;
      req_chan.data_sample  <= '0;
      csr_we    <= 1'b0;
      csr_index <= CSR_CLOCK_LOST_RANGE;
      csr_wdata <= '0;
      reset     <= 1'b1;
      error_count   = 0;
      sent_count    = 0;
      send_idle_pct = 23;
      recv_idle_pct = 71;
      win_fill  = 0;
      rx_phase  = PH_IDLE_HIGH;
      bit_count = '0;
      shift_reg = '0;
      cfg = '{CLOCK_LOST_RANGE_RST, DATA_IDLE_RANGE_RST, 1'b0, 1'b0};
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_lost_clock_at_finish();
      test_sample_extremes();
      test_settings_sweep();

      // drop valid, let every result arrive, then watch for strays
      req_chan.valid <= 1'b0;
      while (pend_wr != pend_rd) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
